### hdl/i2cseq_pkg.sv
// i2cseq_pkg: shared types, codes and constants of the i2c transaction sequencer
// used by i2cseq_step, i2c_master_transaction_sequencer_core and i2cseq_checker
// no dependencies

package i2cseq_pkg;

  // default and widths
  localparam int MAX_ADDR_BYTES_DEF = 4;
  localparam int ABL_W              = 3;
  localparam int IN_TDATA_W         = 80;
  localparam int OUT_TDATA_W        = 24;

  // request kinds
  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_STOPPED = 2'd2;

  // sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_SLA    = 3'd2;
  localparam logic [2:0] PH_IADDR  = 3'd3;
  localparam logic [2:0] PH_TXDATA = 3'd4;
  localparam logic [2:0] PH_RX     = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  // bus actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RACK    = 3'd3;
  localparam logic [2:0] ACT_RNACK   = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NACK = 2'd1;
  localparam logic [1:0] ERR_BUSY = 2'd2;

  // bus status codes, low three bits masked off
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_TX_ACK    = 8'h28;
  localparam logic [7:0] ST_TX_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB       = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        read_mode;
    logic [6:0]  slave_addr;
    logic [31:0] mem_addr;
    logic [2:0]  addr_bytes;
    logic [7:0]  byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  next_tx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic             reading;
    logic             read_after_write;
    logic [6:0]       target_addr;
    logic [31:0]      inner_addr;
    logic [ABL_W-1:0] addr_bytes_left;
    logic [7:0]       bytes_left;
    logic [1:0]       error_held;
  } state_t;

endpackage

### hdl/i2cseq_step.sv
// i2cseq_step: next-state and result logic for one beat of the sequencer
// depends on i2cseq_pkg

module i2cseq_step #(
  parameter int MAX_ADDR_BYTES = i2cseq_pkg::MAX_ADDR_BYTES_DEF
) (
  input  i2cseq_pkg::item_t   item,
  input  i2cseq_pkg::state_t  cur,
  output i2cseq_pkg::state_t  nxt,
  output i2cseq_pkg::result_t res
);

  localparam logic [2:0] MAX_AB = 3'(MAX_ADDR_BYTES);

  logic [7:0]                   st;
  logic                         rdphase;
  logic [2:0]                   ab_sat;
  logic [1:0]                   sel;
  logic [7:0]                   addr_byte;
  logic [7:0]                   bl_dec;

  // status code and direction of the current address phase
  assign st      = item.status_code & i2cseq_pkg::ST_MASK;
  assign rdphase = cur.reading && !cur.read_after_write;
  assign ab_sat  = (item.addr_bytes > MAX_AB) ? MAX_AB : item.addr_bytes;
  assign sel     = 2'(cur.addr_bytes_left - i2cseq_pkg::ABL_W'(1));
  assign bl_dec  = (cur.bytes_left != 8'd0) ? (cur.bytes_left - 8'd1) : 8'd0;

  // internal address byte, most significant first
  always_comb begin
    unique case (sel)
      2'd0:    addr_byte = cur.inner_addr[7:0];
      2'd1:    addr_byte = cur.inner_addr[15:8];
      2'd2:    addr_byte = cur.inner_addr[23:16];
      default: addr_byte = cur.inner_addr[31:24];
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.req_type)
      // new command, taken only when idle
      i2cseq_pkg::REQ_CMD: begin
        if (cur.phase == i2cseq_pkg::PH_IDLE) begin
          nxt.reading          = item.read_mode;
          nxt.target_addr      = item.slave_addr;
          nxt.inner_addr       = item.mem_addr;
          nxt.addr_bytes_left  = ab_sat;
          nxt.bytes_left       = (item.read_mode && item.byte_count == 8'd0) ?
                                 8'd1 : item.byte_count;
          nxt.read_after_write = item.read_mode && (ab_sat != 3'd0);
          nxt.error_held       = i2cseq_pkg::ERR_NONE;
          nxt.phase            = i2cseq_pkg::PH_START;
          res.action           = i2cseq_pkg::ACT_START;
        end
      end
      // bus status after the interrupt flag
      i2cseq_pkg::REQ_STATUS: begin
        unique case (cur.phase)
          i2cseq_pkg::PH_START: begin
            if (st == i2cseq_pkg::ST_START || st == i2cseq_pkg::ST_RSTART) begin
              res.action   = i2cseq_pkg::ACT_SEND;
              res.bus_byte = {cur.target_addr, rdphase};
              nxt.phase    = i2cseq_pkg::PH_SLA;
            end else begin
              res.action     = i2cseq_pkg::ACT_RELEASE;
              res.done_res   = 1'b1;
              res.error_code = i2cseq_pkg::ERR_BUSY;
              nxt.phase      = i2cseq_pkg::PH_IDLE;
            end
          end
          i2cseq_pkg::PH_SLA, i2cseq_pkg::PH_IADDR, i2cseq_pkg::PH_TXDATA: begin
            priority if (cur.phase == i2cseq_pkg::PH_SLA && rdphase &&
                         st == i2cseq_pkg::ST_SLAR_ACK) begin
              res.action = (cur.bytes_left > 8'd1) ? i2cseq_pkg::ACT_RACK :
                                                     i2cseq_pkg::ACT_RNACK;
              nxt.phase  = i2cseq_pkg::PH_RX;
            end else if ((cur.phase == i2cseq_pkg::PH_SLA && rdphase &&
                          st == i2cseq_pkg::ST_SLAR_NACK) ||
                         (cur.phase == i2cseq_pkg::PH_SLA && !rdphase &&
                          st == i2cseq_pkg::ST_SLAW_NACK) ||
                         (cur.phase != i2cseq_pkg::PH_SLA &&
                          st == i2cseq_pkg::ST_TX_NACK)) begin
              res.action     = i2cseq_pkg::ACT_STOP;
              nxt.error_held = i2cseq_pkg::ERR_NACK;
              nxt.phase      = i2cseq_pkg::PH_STOP;
            end else if ((cur.phase == i2cseq_pkg::PH_SLA && !rdphase &&
                          st == i2cseq_pkg::ST_SLAW_ACK) ||
                         (cur.phase != i2cseq_pkg::PH_SLA &&
                          st == i2cseq_pkg::ST_TX_ACK)) begin
              // next address byte, data byte or stop
              priority if (cur.addr_bytes_left != '0) begin
                res.action          = i2cseq_pkg::ACT_SEND;
                res.bus_byte        = addr_byte;
                nxt.addr_bytes_left = cur.addr_bytes_left - i2cseq_pkg::ABL_W'(1);
                nxt.phase           = i2cseq_pkg::PH_IADDR;
              end else if (cur.bytes_left != 8'd0 && !cur.read_after_write) begin
                res.action     = i2cseq_pkg::ACT_SEND;
                res.bus_byte   = item.next_tx_byte;
                nxt.bytes_left = bl_dec;
                nxt.phase      = i2cseq_pkg::PH_TXDATA;
              end else begin
                res.action     = i2cseq_pkg::ACT_STOP;
                nxt.error_held = i2cseq_pkg::ERR_NONE;
                nxt.phase      = i2cseq_pkg::PH_STOP;
              end
            end else begin
              res.action     = i2cseq_pkg::ACT_RELEASE;
              res.done_res   = 1'b1;
              res.error_code = i2cseq_pkg::ERR_BUSY;
              nxt.phase      = i2cseq_pkg::PH_IDLE;
            end
          end
          i2cseq_pkg::PH_RX: begin
            if (st == i2cseq_pkg::ST_RX_ACK || st == i2cseq_pkg::ST_RX_NACK) begin
              res.rx_valid   = 1'b1;
              res.rx_data    = item.rx_byte;
              nxt.bytes_left = bl_dec;
              if (st == i2cseq_pkg::ST_RX_ACK && bl_dec != 8'd0) begin
                res.action = (bl_dec > 8'd1) ? i2cseq_pkg::ACT_RACK :
                                               i2cseq_pkg::ACT_RNACK;
                nxt.phase  = i2cseq_pkg::PH_RX;
              end else begin
                res.action     = i2cseq_pkg::ACT_STOP;
                nxt.error_held = i2cseq_pkg::ERR_NONE;
                nxt.phase      = i2cseq_pkg::PH_STOP;
              end
            end else begin
              res.action     = i2cseq_pkg::ACT_RELEASE;
              res.done_res   = 1'b1;
              res.error_code = i2cseq_pkg::ERR_BUSY;
              nxt.phase      = i2cseq_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      // stop condition finished on the bus
      i2cseq_pkg::REQ_STOPPED: begin
        if (cur.phase == i2cseq_pkg::PH_STOP) begin
          nxt.read_after_write = 1'b0;
          if (cur.read_after_write && cur.error_held == i2cseq_pkg::ERR_NONE) begin
            res.action = i2cseq_pkg::ACT_START;
            nxt.phase  = i2cseq_pkg::PH_START;
          end else begin
            res.done_res   = 1'b1;
            res.error_code = cur.error_held;
            nxt.phase      = i2cseq_pkg::PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/i2c_master_transaction_sequencer_core.sv
// i2c_master_transaction_sequencer_core: top level of the i2c transaction sequencer
// depends on i2cseq_pkg and i2cseq_step
//
// usage
//   in_*  : one beat per command or bus event; in_tuser carries the request kind
//           (new command, bus status, stop finished), in_tdata the command and
//           status fields. every input beat yields exactly one output beat.
//   out_* : next bus action, byte to send, received byte, done flag and error.
// pipeline: input register, then the output register that drives out_tvalid.
// throughput: one beat per cycle while not stalled; the input register feeds
//   the step logic and the sequencer state and output register are written
//   together, so a beat that depends on the one before it is not held back.
// reset: rst_n low clears both valid flags and returns the sequencer to idle
//   with no transaction pending.
// stall: while out_tready is low the result stays in the output register; one
//   more beat is held in the input register and in_tready then drops.

module i2c_master_transaction_sequencer_core #(
  parameter int MAX_ADDR_BYTES = i2cseq_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // read_mode[0], slave_addr[7:1], mem_addr[39:8], addr_bytes[42:40],
  // byte_count[50:43], status_code[58:51], rx_byte[66:59], next_tx_byte[74:67]
  input  logic [i2cseq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // action[2:0], bus_byte[10:3], rx_valid[11], rx_data[19:12], done_res[20],
  // error_code[22:21]
  output logic [i2cseq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                  in_vld_r;
  i2cseq_pkg::item_t     item_r;
  logic                  out_vld_r;
  i2cseq_pkg::result_t   res_r;
  i2cseq_pkg::result_t   res_nxt;
  i2cseq_pkg::state_t    state_r;
  i2cseq_pkg::state_t    state_nxt;
  i2cseq_pkg::item_t     item_in;
  logic                  adv;

  // unpack the input beat
  always_comb begin
    item_in.req_type     = in_tuser;
    item_in.read_mode    = in_tdata[0];
    item_in.slave_addr   = in_tdata[7:1];
    item_in.mem_addr     = in_tdata[39:8];
    item_in.addr_bytes   = in_tdata[42:40];
    item_in.byte_count   = in_tdata[50:43];
    item_in.status_code  = in_tdata[58:51];
    item_in.rx_byte      = in_tdata[66:59];
    item_in.next_tx_byte = in_tdata[74:67];
  end

  // handshake between input register and output register
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_r <= item_in;
    end
  end

  i2cseq_step #(
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
  ) u_step (
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // sequencer state, updated as each beat moves to the output
  // idle is the all-zero phase code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r.error_code, res_r.done_res, res_r.rx_data,
                       res_r.rx_valid, res_r.bus_byte, res_r.action};

endmodule

### hdl/i2cseq_checker.sv
// i2cseq_checker: port-level assertions for the i2c transaction sequencer
// depends on i2cseq_pkg; bound to i2c_master_transaction_sequencer_core

module i2cseq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [i2cseq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [2:0] act;
  logic [7:0] bbyte;
  logic       rxv;
  logic       done;
  logic [1:0] err;

  assign act   = out_tdata[2:0];
  assign bbyte = out_tdata[10:3];
  assign rxv   = out_tdata[11];
  assign done  = out_tdata[20];
  assign err   = out_tdata[22:21];

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a finished transaction either releases the bus or reports after stop
  a_done_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && done |->
      (act == i2cseq_pkg::ACT_RELEASE || act == i2cseq_pkg::ACT_NONE))
    else $error("done with unexpected action");

  // a received byte comes with a further read or a stop
  a_rx_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rxv |->
      (act == i2cseq_pkg::ACT_RACK || act == i2cseq_pkg::ACT_RNACK ||
       act == i2cseq_pkg::ACT_STOP))
    else $error("received byte with unexpected action");

  // errors are reported only when the transaction ends
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (err != i2cseq_pkg::ERR_NONE) |-> done)
    else $error("error code without done");

  // a bus byte is driven only for a send
  a_byte_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (bbyte != 8'd0) |-> (act == i2cseq_pkg::ACT_SEND))
    else $error("bus byte without send action");

endmodule

bind i2c_master_transaction_sequencer_core i2cseq_checker u_i2cseq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
